>>> design/ptic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptic_pkg
// Types, field widths and register codes shared by the timer and IRQ
// controller.
// ----------------------------------------------------------------------------
package ptic_pkg;

    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int LINE_W     = 9;
    localparam int DOT_W      = 9;
    localparam int PRESCALE_W = 5;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 16;
    localparam int M_USED_W   = BYTE_W + 1;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DOT   = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_MASK    = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_STATUS  = 3'd1;
    localparam logic [ADDR_W-1:0] ADDR_CONTROL = 3'd2;
    localparam logic [ADDR_W-1:0] ADDR_LATCH   = 3'd3;
    localparam logic [ADDR_W-1:0] ADDR_COUNT   = 3'd4;

    localparam logic [BYTE_W-1:0] TMR_ENABLE   = 8'h80;
    localparam logic [BYTE_W-1:0] TMR_REPEAT   = 8'h40;
    localparam logic [BYTE_W-1:0] TMR_SCANLINE = 8'h20;
    localparam logic [BYTE_W-1:0] TMR_PRESCALE = 8'h0F;
    localparam logic [BYTE_W-1:0] ST_TIMER     = 8'h80;
    localparam logic [BYTE_W-1:0] ST_SERIAL    = 8'h40;
    localparam logic [BYTE_W-1:0] ST_PS2       = 8'h20;
    localparam logic [BYTE_W-1:0] ST_FDC       = 8'h08;
    localparam logic [BYTE_W-1:0] MASK_RESET   = 8'hFF;
    localparam logic [DOT_W-1:0]  DOT_THRESHOLD = 9'd330;

    typedef struct packed {
        logic              serial_event;
        logic              ps2_event;
        logic              fdc_irq_level;
        logic [DOT_W-1:0]  dot_number;
        logic [LINE_W-1:0] scanline_number;
        logic [BYTE_W-1:0] write_data;
        logic [ADDR_W-1:0] reg_addr;
    } item_data_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        item_data_t          data;
    } item_t;

    typedef struct packed {
        logic              irq_out;
        logic [BYTE_W-1:0] read_data;
    } result_t;

endpackage

>>> design/ptic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptic_core
// Register file, prescaler and counter. Applies one item per enabled cycle
// and returns the read byte and interrupt level after that item.
// ----------------------------------------------------------------------------
module ptic_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  ptic_pkg::item_t  item,
    output ptic_pkg::result_t result
);
    import ptic_pkg::*;

    logic [BYTE_W-1:0]     mask_reg, mask_next;
    logic [BYTE_W-1:0]     status_reg, status_next;
    logic [BYTE_W-1:0]     control_reg, control_next;
    logic [BYTE_W-1:0]     latch_reg, latch_next;
    logic [BYTE_W-1:0]     count_reg, count_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [LINE_W-1:0]     line_reg, line_next;

    logic                  do_advance;
    logic [PRESCALE_W-1:0] pre_inc;
    logic [PRESCALE_W-1:0] pre_limit;
    logic [BYTE_W-1:0]     count_inc;
    logic [BYTE_W-1:0]     status_pre;
    logic [BYTE_W-1:0]     rd;

    always_comb begin
        mask_next     = mask_reg;
        status_pre    = status_reg;
        control_next  = control_reg;
        latch_next    = latch_reg;
        count_next    = count_reg;
        prescale_next = prescale_reg;
        line_next     = line_reg;
        do_advance    = 1'b0;
        rd            = '0;

        unique case (item.action)
            ACT_WRITE: begin
                priority if (item.data.reg_addr == ADDR_MASK) begin
                    mask_next  = item.data.write_data;
                    status_pre = status_reg & ~item.data.write_data;
                end else if (item.data.reg_addr == ADDR_CONTROL) begin
                    control_next = item.data.write_data;
                    if ((item.data.write_data & TMR_ENABLE) == '0) begin
                        status_pre = status_reg & ~ST_TIMER;
                    end
                end else if (item.data.reg_addr == ADDR_LATCH) begin
                    latch_next = item.data.write_data;
                    count_next = '0;
                    status_pre = status_reg & ~ST_TIMER;
                end else begin
                end
            end
            ACT_READ: begin
                unique case (item.data.reg_addr)
                    ADDR_MASK:    rd = mask_reg;
                    ADDR_STATUS:  rd = status_reg;
                    ADDR_CONTROL: rd = control_reg;
                    ADDR_LATCH:   rd = latch_reg;
                    ADDR_COUNT:   rd = count_reg;
                    default:      rd = '0;
                endcase
            end
            ACT_TICK: begin
                status_pre = item.data.fdc_irq_level ? (status_reg | ST_FDC)
                                                     : (status_reg & ~ST_FDC);
                if (item.data.ps2_event) begin
                    status_pre = status_pre | ST_PS2;
                end
                if (item.data.serial_event) begin
                    status_pre = status_pre | ST_SERIAL;
                end
                do_advance = (control_reg & TMR_SCANLINE) == '0;
            end
            default: begin
                if (item.data.dot_number >= DOT_THRESHOLD &&
                    item.data.scanline_number != line_reg &&
                    (control_reg & TMR_SCANLINE) != '0) begin
                    line_next  = item.data.scanline_number;
                    do_advance = 1'b1;
                end
            end
        endcase

        status_next = status_pre;
        pre_inc     = prescale_reg + 1'b1;
        pre_limit   = {1'b0, control_reg[3:0]} + 1'b1;
        count_inc   = count_reg + 1'b1;
        if (do_advance) begin
            if (pre_inc >= pre_limit) begin
                prescale_next = '0;
                if (count_inc > latch_reg) begin
                    count_next = '0;
                    if ((control_reg & TMR_ENABLE) != '0) begin
                        status_next = status_pre | ST_TIMER;
                    end
                    if ((control_reg & TMR_REPEAT) == '0) begin
                        control_next = control_reg & ~TMR_ENABLE;
                    end
                end else begin
                    count_next = count_inc;
                end
            end else begin
                prescale_next = pre_inc;
            end
        end

        result.read_data = rd;
        result.irq_out   = (status_next & ~mask_next) != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= MASK_RESET;
            status_reg   <= '0;
            control_reg  <= '0;
            latch_reg    <= '0;
            count_reg    <= '0;
            prescale_reg <= '0;
            line_reg     <= '0;
        end else if (step_en) begin
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            control_reg  <= control_next;
            latch_reg    <= latch_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            line_reg     <= line_next;
        end
    end

endmodule

>>> design/prescaled_timer_irq_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_timer_irq_controller_top
// Stream wrapper around the timer and interrupt controller core.
// ----------------------------------------------------------------------------
// Each input transfer is a bus write, a bus read, a processor tick or a video
// dot event, and yields exactly one output transfer carrying the read byte
// (zero unless a read) and the interrupt level after that transfer. One
// transfer is taken every clock unless the output stalls; it passes the input
// register and the result register around the core's register update.
// The block has no reset sweep: it takes transfers the cycle after reset.
module prescaled_timer_irq_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // reg_addr, write_data, scanline_number, dot_number, fdc_irq_level,
    // ps2_event, serial_event
    input  logic [ptic_pkg::S_DATA_W-1:0]   s_tdata,
    // action
    input  logic [ptic_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data, irq_out, zero fill
    output logic [ptic_pkg::M_DATA_W-1:0]   m_tdata
);
    import ptic_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    result_t core_result;
    logic    step_en;
    logic    s_fire;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !step_en);
    assign out_valid_next = step_en || (out_valid_reg && !m_tready);

    ptic_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= {s_tuser, s_tdata};
        end
        if (step_en) begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - M_USED_W){1'b0}}, out_data_reg};

endmodule

>>> design/ptic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptic_checker
// Port-level checks on the timer and interrupt controller stream channels.
// ----------------------------------------------------------------------------
module ptic_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ptic_pkg::S_DATA_W-1:0] s_tdata,
    input logic [ptic_pkg::ACTION_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptic_pkg::M_DATA_W-1:0] m_tdata
);
    import ptic_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // hold a waiting input transfer
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input changed while waiting");

    // drop output valid on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // accept input right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // keep fill bits clear
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:M_USED_W] == '0)
        else $error("nonzero fill bits in result");

endmodule

bind prescaled_timer_irq_controller_top ptic_checker u_ptic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the prescaled timer and interrupt controller.
// ----------------------------------------------------------------------------
// Drives bus writes, bus reads, processor ticks and video dot events into the
// input stream. A scoreboard carries its own copy of the register file,
// prescaler and counter, and forms the expected read byte and interrupt level
// for every accepted transfer. Each output transfer is compared field by field
// with the oldest expected result. A directed opening covers register
// reset values, ignored writes, event bits, prescale lowered in mid-count and
// scanline mode. It is followed by weighted random traffic that programs the
// timer into states where it expires. Both sides insert random gaps, and once
// the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import ptic_pkg::*;

    class irq_ctrl_scoreboard;
        logic [BYTE_W-1:0]     mask;
        logic [BYTE_W-1:0]     status;
        logic [BYTE_W-1:0]     control;
        logic [BYTE_W-1:0]     latch;
        logic [BYTE_W-1:0]     count;
        logic [PRESCALE_W-1:0] prescale;
        logic [LINE_W-1:0]     last_line;
        result_t               expected_q[$];
        int unsigned           mismatches;
        int unsigned           results_checked;
        int unsigned           timer_expiries;
        int unsigned           irq_high_results;

        function new();
            mask             = MASK_RESET;
            status           = '0;
            control          = '0;
            latch            = '0;
            count            = '0;
            prescale         = '0;
            last_line        = '0;
            mismatches       = 0;
            results_checked  = 0;
            timer_expiries   = 0;
            irq_high_results = 0;
        endfunction

        function void step_timer();
            logic [PRESCALE_W-1:0] next_pre;
            logic [PRESCALE_W-1:0] limit;
            next_pre = prescale + 1'b1;
            limit    = {1'b0, control[3:0]} + 1'b1;
            if (next_pre >= limit) begin
                prescale = '0;
                count    = count + 1'b1;
                if ({1'b0, count} >= {1'b0, latch} + 9'd1) begin
                    count = '0;
                    if ((control & TMR_ENABLE) != 0) begin
                        status = status | ST_TIMER;
                        timer_expiries++;
                    end
                    if ((control & TMR_REPEAT) == 0)
                        control = control & ~TMR_ENABLE;
                end
            end else begin
                prescale = next_pre;
            end
        endfunction

        function void note_input(item_t it);
            result_t          want;
            logic [BYTE_W-1:0] rd;
            rd = '0;
            case (it.action)
                ACT_WRITE: begin
                    case (it.data.reg_addr)
                        ADDR_MASK: begin
                            mask   = it.data.write_data;
                            status = status & ~mask;
                        end
                        ADDR_CONTROL: begin
                            control = it.data.write_data;
                            if ((control & TMR_ENABLE) == 0)
                                status = status & ~ST_TIMER;
                        end
                        ADDR_LATCH: begin
                            latch  = it.data.write_data;
                            count  = '0;
                            status = status & ~ST_TIMER;
                        end
                        default: ;
                    endcase
                end
                ACT_READ: begin
                    case (it.data.reg_addr)
                        ADDR_MASK:    rd = mask;
                        ADDR_STATUS:  rd = status;
                        ADDR_CONTROL: rd = control;
                        ADDR_LATCH:   rd = latch;
                        ADDR_COUNT:   rd = count;
                        default:      rd = '0;
                    endcase
                end
                ACT_TICK: begin
                    if (it.data.fdc_irq_level)
                        status = status | ST_FDC;
                    else
                        status = status & ~ST_FDC;
                    if (it.data.ps2_event)
                        status = status | ST_PS2;
                    if (it.data.serial_event)
                        status = status | ST_SERIAL;
                    if ((control & TMR_SCANLINE) == 0)
                        step_timer();
                end
                default: begin
                    if (it.data.dot_number >= DOT_THRESHOLD &&
                        it.data.scanline_number != last_line &&
                        (control & TMR_SCANLINE) != 0) begin
                        last_line = it.data.scanline_number;
                        step_timer();
                    end
                end
            endcase
            want.read_data = rd;
            want.irq_out   = |(status & ~mask);
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string field, int unsigned got, int unsigned want);
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $time, results_checked, field, got, want);
            mismatches++;
        endtask

        task check_result(logic [M_DATA_W-1:0] word);
            result_t got;
            result_t want;
            got = word[M_USED_W-1:0];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", word, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.irq_out !== want.irq_out)
                    report_mismatch("irq_out", got.irq_out, want.irq_out);
                if (word[M_DATA_W-1:M_USED_W] !== '0)
                    report_mismatch("fill bits", word[M_DATA_W-1:M_USED_W], 0);
                if (want.irq_out)
                    irq_high_results++;
            end
            results_checked++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [ACTION_W-1:0]   s_tuser  = ACT_WRITE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    irq_ctrl_scoreboard    sb;
    logic [LINE_W-1:0]     line_cursor = '0;
    int unsigned           sender_style = 0;
    bit                    holding_off = 1'b0;
    int unsigned           action_count[4] = '{0, 0, 0, 0};

    prescaled_timer_irq_controller_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic item_t make_item(logic [ACTION_W-1:0] action,
                                        logic [ADDR_W-1:0] addr,
                                        logic [BYTE_W-1:0] wdata,
                                        logic [LINE_W-1:0] line = '0,
                                        logic [DOT_W-1:0] dot = '0,
                                        logic fdc = 1'b0,
                                        logic ps2 = 1'b0,
                                        logic ser = 1'b0);
        item_t it;
        it.action               = action;
        it.data.reg_addr        = addr;
        it.data.write_data      = wdata;
        it.data.scanline_number = line;
        it.data.dot_number      = dot;
        it.data.fdc_irq_level   = fdc;
        it.data.ps2_event       = ps2;
        it.data.serial_event    = ser;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        it.data = item_data_t'($urandom());
        it.data.dot_number = DOT_W'($urandom_range(0, 340));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            it.action = ACT_WRITE;
            it.data.reg_addr = ADDR_CONTROL;
            if ($urandom_range(0, 9) < 7)
                it.data.write_data[3:0] = 4'($urandom_range(0, 3));
            it.data.write_data[7] = ($urandom_range(0, 9) < 6);
            it.data.write_data[5] = ($urandom_range(0, 3) == 0);
        end else if (pick < 13) begin
            it.action = ACT_WRITE;
            it.data.reg_addr = ADDR_LATCH;
            if ($urandom_range(0, 3) != 0)
                it.data.write_data = BYTE_W'($urandom_range(0, 7));
        end else if (pick < 17) begin
            it.action = ACT_WRITE;
            it.data.reg_addr = ADDR_MASK;
            if ($urandom_range(0, 1) == 0)
                it.data.write_data = it.data.write_data & ~ST_TIMER;
        end else if (pick < 20) begin
            it.action = ACT_WRITE;
            it.data.reg_addr = ($urandom_range(0, 4) == 0) ? ADDR_STATUS
                                                          : ADDR_W'($urandom_range(4, 7));
        end else if (pick < 35) begin
            it.action = ACT_READ;
        end else if (pick < 80) begin
            it.action = ACT_TICK;
            it.data.ps2_event    = ($urandom_range(0, 4) == 0);
            it.data.serial_event = ($urandom_range(0, 4) == 0);
        end else begin
            it.action = ACT_DOT;
            if ($urandom_range(0, 1) == 0)
                it.data.scanline_number = line_cursor + 1'b1;
            if ($urandom_range(0, 9) < 6)
                it.data.dot_number = DOT_W'($urandom_range(330, 340));
            line_cursor = it.data.scanline_number;
        end
        return it;
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned roll;
        if (holding_off)
            return 0;
        case (sender_style)
            0: return 0;
            1: return ($urandom_range(0, 9) < 3) ? $urandom_range(1, 2) : 0;
            default: begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    return $urandom_range(10, 40);
                return (roll < 6) ? $urandom_range(1, 3) : 0;
            end
        endcase
    endfunction

    task automatic send_item(input item_t it);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= it.action;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(it);
        action_count[it.action]++;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // output side: random stalls, changes of stall style, one long hold-off
    initial begin : result_sink
        int unsigned cycle_n;
        int unsigned sink_style;
        int unsigned stall_left;
        int unsigned pressure_left;
        bit          pressure_done;
        cycle_n       = 0;
        sink_style    = 0;
        stall_left    = 0;
        pressure_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (!pressure_done && sb.results_checked >= 500) begin
                pressure_done = 1'b1;
                pressure_left = 200;
            end
            if (cycle_n % 64 == 0)
                sink_style = $urandom_range(0, 2);
            cycle_n++;
            holding_off = (pressure_left > 0);
            if (pressure_left > 0) begin
                pressure_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_style == 0) begin
                m_tready <= 1'b1;
            end else if (sink_style == 1) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                if ($urandom_range(0, 19) == 0)
                    stall_left = $urandom_range(5, 30);
                m_tready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    initial begin : stimulus
        item_t directed_q[$];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_q = '{
            make_item(ACT_READ,  ADDR_MASK,    8'h00),
            make_item(ACT_READ,  ADDR_STATUS,  8'hFF),
            make_item(ACT_READ,  ADDR_CONTROL, 8'h00),
            make_item(ACT_READ,  ADDR_COUNT,   8'h00),
            make_item(ACT_READ,  3'd7,         8'h00),
            make_item(ACT_WRITE, ADDR_MASK,    8'h00),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00, 9'd0, 9'd0, 1'b1, 1'b1, 1'b1),
            make_item(ACT_READ,  ADDR_STATUS,  8'h00),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_WRITE, ADDR_STATUS,  8'hFF),
            make_item(ACT_WRITE, ADDR_COUNT,   8'hFF),
            make_item(ACT_WRITE, ADDR_MASK,    8'hFF),
            make_item(ACT_WRITE, ADDR_MASK,    8'h00),
            make_item(ACT_WRITE, ADDR_LATCH,   8'h01),
            make_item(ACT_WRITE, ADDR_CONTROL, TMR_ENABLE | TMR_REPEAT | TMR_PRESCALE),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_WRITE, ADDR_CONTROL, TMR_ENABLE | TMR_REPEAT),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_READ,  ADDR_STATUS,  8'h00),
            make_item(ACT_WRITE, ADDR_CONTROL, TMR_ENABLE | TMR_SCANLINE),
            make_item(ACT_DOT,   ADDR_MASK,    8'h00, 9'd5,   9'd330),
            make_item(ACT_DOT,   ADDR_MASK,    8'h00, 9'd5,   9'd340),
            make_item(ACT_DOT,   ADDR_MASK,    8'h00, 9'd6,   9'd329),
            make_item(ACT_DOT,   ADDR_MASK,    8'h00, 9'd511, 9'd335),
            make_item(ACT_TICK,  ADDR_MASK,    8'h00),
            make_item(ACT_WRITE, ADDR_LATCH,   8'hFF)
        };
        foreach (directed_q[i])
            send_item(directed_q[i]);

        for (int n = 0; n < 1330; n++) begin
            if (n % 40 == 0)
                sender_style = $urandom_range(0, 2);
            send_item(random_item());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d writes, %0d reads, %0d processor ticks, %0d dot events.",
                 action_count[ACT_WRITE], action_count[ACT_READ],
                 action_count[ACT_TICK], action_count[ACT_DOT]);
        $display("Timer expired %0d times; %0d of %0d results had the interrupt high.",
                 sb.timer_expiries, sb.irq_high_results, sb.results_checked);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : build
        sb = new();
    end
endmodule
